// ===== hdl/lbpg_pkg.sv =====
// lbpg_pkg: shared types, action codes and timing constants of the led blink
// pattern generator
// no dependencies
`default_nettype none

package lbpg_pkg;

  // field widths of one input beat, fixed by the interface
  localparam int unsigned ActionW = 3;
  localparam int unsigned CountW  = 16;
  localparam int unsigned TimeW   = 16;

  // parameter defaults
  localparam int unsigned DefTimeBits  = 16;
  localparam int unsigned DefCountBits = 16;

  // error burst timing in ms ticks
  localparam longint unsigned ErrOnMs    = 100;
  localparam longint unsigned ErrOffMs   = 400;
  localparam longint unsigned ErrPauseMs = 2000;

  typedef enum logic [ActionW-1:0] {
    ACT_TICK  = 3'd0,
    ACT_OFF   = 3'd1,
    ACT_ON    = 3'd2,
    ACT_BLINK = 3'd3,
    ACT_ERROR = 3'd4
  } action_e;

  typedef struct packed {
    logic [ActionW-1:0] action;
    logic [CountW-1:0]  count;
    logic               forever_req;
    logic [TimeW-1:0]   on_time;
    logic [TimeW-1:0]   off_time;
  } item_t;

  // input stage contents handed to the engine
  typedef struct packed {
    logic  valid;
    item_t item;
  } stage_t;

  // clamp a constant to the largest value of a given number of bits
  function automatic longint unsigned sat_const(longint unsigned v, int unsigned bits);
    longint unsigned lim;
    lim = (64'd1 << bits) - 64'd1;
    return (v > lim) ? lim : v;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/lbpg_in_stage.sv =====
// lbpg_in_stage: input register that holds one beat until the engine takes it
// depends on lbpg_pkg
`default_nettype none

module lbpg_in_stage
  import lbpg_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   in_valid_i,
  input  wire item_t  in_item_i,
  input  wire logic   advance_i,
  output logic        in_ready_o,
  output stage_t      stage_o
);

  logic  valid_q, valid_d;
  item_t item_q;

  // room when empty or when the held beat moves on this cycle
  assign in_ready_o = !valid_q || advance_i;
  assign valid_d    = in_ready_o ? in_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= in_item_i;
    end
  end

  assign stage_o.valid = valid_q;
  assign stage_o.item  = item_q;

endmodule

`default_nettype wire

// ===== hdl/lbpg_engine.sv =====
// lbpg_engine: blink state, one-pass update per beat and the result register
// depends on lbpg_pkg
`default_nettype none

module lbpg_engine
  import lbpg_pkg::*;
#(
  parameter int unsigned TIME_BITS  = DefTimeBits,
  parameter int unsigned COUNT_BITS = DefCountBits
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire stage_t stage_i,
  output logic        advance_o,
  output logic        out_valid_o,
  input  wire logic   out_ready_i,
  output logic        led_level_o,
  output logic        busy_res_o
);

  localparam logic [TIME_BITS-1:0] ErrOn    = TIME_BITS'(sat_const(ErrOnMs, TIME_BITS));
  localparam logic [TIME_BITS-1:0] ErrOff   = TIME_BITS'(sat_const(ErrOffMs, TIME_BITS));
  localparam logic [TIME_BITS-1:0] ErrPause = TIME_BITS'(sat_const(ErrPauseMs, TIME_BITS));
  localparam logic [TIME_BITS-1:0] TimeOne  = TIME_BITS'(1);
  localparam logic [COUNT_BITS-1:0] CntOne  = COUNT_BITS'(1);

  logic                  lit_q, lit_d;
  logic                  active_q, active_d;
  logic                  endless_q, endless_d;
  logic [COUNT_BITS-1:0] left_q, left_d;
  logic [COUNT_BITS-1:0] burst_q, burst_d;
  logic [TIME_BITS-1:0]  wait_q, wait_d;
  logic [TIME_BITS-1:0]  on_len_q, on_len_d;
  logic [TIME_BITS-1:0]  off_len_q, off_len_d;
  logic                  out_valid_q, out_valid_d;
  logic                  led_q, busy_q;

  logic                  fire;
  logic [COUNT_BITS-1:0] cnt;
  logic [COUNT_BITS-1:0] err_cnt;
  logic [COUNT_BITS-1:0] left_dec;
  logic [TIME_BITS-1:0]  t_on, t_off;

  assign advance_o   = !out_valid_q || out_ready_i;
  assign fire        = stage_i.valid && advance_o;
  assign out_valid_d = stage_i.valid || (out_valid_q && !out_ready_i);

  assign cnt      = COUNT_BITS'(stage_i.item.count);
  assign err_cnt  = (cnt == '0) ? CntOne : cnt;
  assign t_on     = TIME_BITS'(stage_i.item.on_time);
  assign t_off    = TIME_BITS'(stage_i.item.off_time);
  assign left_dec = endless_q ? left_q : left_q - CntOne;

  always_comb begin
    lit_d     = lit_q;
    active_d  = active_q;
    endless_d = endless_q;
    left_d    = left_q;
    burst_d   = burst_q;
    wait_d    = wait_q;
    on_len_d  = on_len_q;
    off_len_d = off_len_q;
    unique case (stage_i.item.action)
      ACT_TICK: begin
        if (active_q) begin
          if (wait_q > TimeOne) begin
            wait_d = wait_q - TimeOne;
          end else if (lit_q) begin
            // end of on phase
            lit_d  = 1'b0;
            left_d = left_dec;
            if (!endless_q && left_dec == '0) begin
              if (burst_q != '0) begin
                left_d = burst_q;
                wait_d = ErrPause;
              end else begin
                active_d = 1'b0;
                wait_d   = '0;
              end
            end else begin
              wait_d = off_len_q;
            end
          end else begin
            lit_d  = 1'b1;
            wait_d = on_len_q;
          end
        end
      end
      ACT_OFF: begin
        lit_d     = 1'b0;
        active_d  = 1'b0;
        left_d    = '0;
        burst_d   = '0;
        endless_d = 1'b0;
      end
      ACT_ON: begin
        lit_d    = 1'b1;
        active_d = 1'b0;
      end
      ACT_BLINK: begin
        if ((!stage_i.item.forever_req && cnt == '0) || t_on == '0) begin
          lit_d     = 1'b0;
          active_d  = 1'b0;
          left_d    = '0;
          burst_d   = '0;
          endless_d = 1'b0;
        end else begin
          lit_d     = 1'b1;
          active_d  = 1'b1;
          burst_d   = '0;
          left_d    = cnt;
          endless_d = stage_i.item.forever_req;
          on_len_d  = t_on;
          off_len_d = t_off;
          wait_d    = t_on;
        end
      end
      ACT_ERROR: begin
        lit_d     = 1'b1;
        active_d  = 1'b1;
        burst_d   = err_cnt;
        left_d    = err_cnt;
        endless_d = 1'b0;
        on_len_d  = ErrOn;
        off_len_d = ErrOff;
        wait_d    = ErrOn;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lit_q       <= 1'b0;
      active_q    <= 1'b0;
      endless_q   <= 1'b0;
      left_q      <= '0;
      burst_q     <= '0;
      wait_q      <= '0;
      on_len_q    <= '0;
      off_len_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance_o) begin
        out_valid_q <= out_valid_d;
      end
      if (fire) begin
        lit_q     <= lit_d;
        active_q  <= active_d;
        endless_q <= endless_d;
        left_q    <= left_d;
        burst_q   <= burst_d;
        wait_q    <= wait_d;
        on_len_q  <= on_len_d;
        off_len_q <= off_len_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      led_q  <= lit_d;
      busy_q <= active_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign led_level_o = led_q;
  assign busy_res_o  = busy_q;

endmodule

`default_nettype wire

// ===== hdl/led_blink_pattern_generator_top.sv =====
// led_blink_pattern_generator_top: top level of the led blink pattern generator
// depends on lbpg_pkg, lbpg_in_stage and lbpg_engine
`default_nettype none

// Drives one LED from a stream of beats: each beat is either a 1 ms tick or a
// command (steady off, steady on, start blink run, start error burst), and
// every accepted beat returns exactly one result beat with the LED level and
// a busy flag. Starts light the LED at once; a blink run with zero count (not
// forever) or zero on time acts as steady off. An error burst blinks
// max(count,1) times 100 ms on / 400 ms off, with a 2000 ms pause in place of
// the last off phase, and repeats until stopped; these times clamp to the
// largest TIME_BITS value. Throughput is one beat per clock while out_ready_i
// holds high: a beat sits in an input register, the state update and result
// are computed in one pass and captured in the result register. While a
// result waits on out_ready_i the input register can still take one more
// beat, then in_ready_o drops until the result is taken. TIME_BITS sets the
// countdown width, COUNT_BITS the blink counter.
module led_blink_pattern_generator_top
  import lbpg_pkg::*;
#(
  parameter int unsigned TIME_BITS  = DefTimeBits,
  parameter int unsigned COUNT_BITS = DefCountBits
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // input beat
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [ActionW-1:0] action_i,
  input  wire logic [CountW-1:0]  count_i,
  input  wire logic               forever_req_i,
  input  wire logic [TimeW-1:0]   on_time_i,
  input  wire logic [TimeW-1:0]   off_time_i,
  // result beat
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic                    led_level_o,
  output logic                    busy_res_o
);

  item_t  in_item;
  stage_t stage;
  logic   advance;

  // pack the input fields
  assign in_item.action      = action_i;
  assign in_item.count       = count_i;
  assign in_item.forever_req = forever_req_i;
  assign in_item.on_time     = on_time_i;
  assign in_item.off_time    = off_time_i;

  // input register
  lbpg_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_item_i  (in_item),
    .advance_i  (advance),
    .in_ready_o (in_ready_o),
    .stage_o    (stage)
  );

  // state update and result register
  lbpg_engine #(
    .TIME_BITS  (TIME_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .stage_i     (stage),
    .advance_o   (advance),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .led_level_o (led_level_o),
    .busy_res_o  (busy_res_o)
  );

  // an empty input register always takes a beat
  a_ready_when_empty: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !stage.valid |-> in_ready_o
  ) else $error("input stage empty but not ready");

  // a held beat that moves on yields a result next cycle
  a_result_follows: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (stage.valid && advance) |=> out_valid_o
  ) else $error("beat consumed without a result");

  // a full input register that cannot drain must block new beats
  a_no_overrun: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (stage.valid && !advance) |-> !in_ready_o
  ) else $error("input stage would be overwritten");

endmodule

`default_nettype wire
